FILE: rtl/csfv_pkg.sv
// Shared constants for the cube-sphere face vertex pipeline.
// Holds the Q30 CORDIC constants, field widths and parameter defaults.
// No dependencies.
package csfv_pkg;

    // Parameter defaults for the top level
    localparam int MAX_SUBDIV_DEF = 8;
    localparam int FRAC_BITS_DEF  = 14;

    // Field widths fixed by the interface
    localparam int IDX_W = 9;
    localparam int CFG_W = 4;
    localparam int OUT_W = 16;

    // Subdivision level after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd6;

    // CORDIC and tangent datapath
    localparam int CORDIC_STEPS = 30;
    localparam int TAN_W        = 32;                     // tangent magnitude, Q30
    localparam int XY_W         = 33;                     // CORDIC x/y, signed
    localparam int ZA_W         = 32;                     // CORDIC angle, signed
    localparam int DEN_TAN_W    = 31;                     // final CORDIC x is below 2^31
    localparam int TAN_LAT      = 2 + CORDIC_STEPS + TAN_W;

    // Norm path
    localparam int SQ_W       = 64;                       // sum of squares
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int NORM_W     = 31;                       // norm is below 2^31

    localparam logic [29:0]     QUARTER_PI = 30'd843314856;   // pi/4 in Q30
    localparam logic [TAN_W-1:0] Q30_ONE   = 32'd1073741824;

    // Truncated arctangent of 2^-k in Q30
    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
    };

endpackage

FILE: rtl/csfv_udiv.sv
// Pipelined restoring divider: one quotient bit per stage, QUO_W stages.
// The quotient must fit QUO_W bits and num >> QUO_W must stay below den.
// Depends on nothing; stalls on en.
module csfv_udiv #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 31,
    parameter int QUO_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [QUO_W-1:0] quo_out
);

    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] low_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];

    logic [DEN_W-1:0] rem_prev [QUO_W];
    logic [QUO_W-1:0] low_prev [QUO_W];
    logic [DEN_W-1:0] den_prev [QUO_W];
    logic [QUO_W-1:0] quo_prev [QUO_W];

    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] low_next [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    // Stage inputs: first stage from the ports, the rest from the stage before
    always_comb begin
        rem_prev[0] = DEN_W'(num_in >> QUO_W);
        low_prev[0] = num_in[QUO_W-1:0];
        den_prev[0] = den_in;
        quo_prev[0] = '0;
        for (int k = 1; k < QUO_W; k++) begin
            rem_prev[k] = rem_reg[k-1];
            low_prev[k] = low_reg[k-1];
            den_prev[k] = den_reg[k-1];
            quo_prev[k] = quo_reg[k-1];
        end
    end

    // Shift in one dividend bit and try a subtract
    always_comb begin
        logic [DEN_W:0] t;
        logic           ge;
        for (int k = 0; k < QUO_W; k++) begin
            t           = {rem_prev[k], low_prev[k][QUO_W-1]};
            ge          = (t >= {1'b0, den_prev[k]});
            rem_next[k] = ge ? DEN_W'(t - {1'b0, den_prev[k]}) : t[DEN_W-1:0];
            low_next[k] = low_prev[k] << 1;
            quo_next[k] = {quo_prev[k][QUO_W-2:0], ge};
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                den_reg[k] <= den_prev[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo_out = quo_reg[QUO_W-1];

endmodule

FILE: rtl/csfv_tan.sv
// Tangent of pi/4 * mag / 2^lvl in Q30: angle scaling, 30-stage rotation
// CORDIC, then a 32-stage divide of |y| by x. Uses csfv_pkg and csfv_udiv.
// One word per cycle, stalls on en.
module csfv_tan #(
    parameter int MAG_W = 9,
    parameter int LVL_W = 4
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [MAG_W-1:0]            mag_in,
    input  logic [LVL_W-1:0]            lvl_in,
    input  logic                        neg_in,
    output logic [csfv_pkg::TAN_W-1:0]  tan_mag,
    output logic                        tan_neg
);

    localparam int STEPS = csfv_pkg::CORDIC_STEPS;
    localparam int XW    = csfv_pkg::XY_W;
    localparam int ZW    = csfv_pkg::ZA_W;
    localparam int TW    = csfv_pkg::TAN_W;
    localparam int NN_D  = 2 + STEPS;

    // Angle scaling
    logic [MAG_W+29:0] prod_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [29:0]       z0_reg;

    // CORDIC stages
    logic signed [XW-1:0] cx_reg  [STEPS];
    logic signed [XW-1:0] cy_reg  [STEPS];
    logic signed [ZW-1:0] cz_reg  [STEPS];
    logic signed [XW-1:0] cx_prev [STEPS];
    logic signed [XW-1:0] cy_prev [STEPS];
    logic signed [ZW-1:0] cz_prev [STEPS];
    logic signed [XW-1:0] cx_next [STEPS];
    logic signed [XW-1:0] cy_next [STEPS];
    logic signed [ZW-1:0] cz_next [STEPS];

    // Sign of the angle, then sign of the result
    logic nn_reg [NN_D];
    logic ng_reg [TW];

    logic signed [XW-1:0]            y_fin;
    logic [TW-1:0]                   y_mag;
    logic [TW+29:0]                  div_num;
    logic [csfv_pkg::DEN_TAN_W-1:0]  div_den;
    logic                            neg_fin;

    // Scale the step count to a Q30 angle, then shift by the level
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= (MAG_W+30)'(mag_in) * (MAG_W+30)'(csfv_pkg::QUARTER_PI);
            lvl_reg  <= lvl_in;
            z0_reg   <= 30'(prod_reg >> lvl_reg);
        end
    end

    // Stage inputs for the rotation
    always_comb begin
        cx_prev[0] = XW'(csfv_pkg::Q30_ONE);
        cy_prev[0] = '0;
        cz_prev[0] = $signed({2'b00, z0_reg});
        for (int k = 1; k < STEPS; k++) begin
            cx_prev[k] = cx_reg[k-1];
            cy_prev[k] = cy_reg[k-1];
            cz_prev[k] = cz_reg[k-1];
        end
    end

    // One micro-rotation per stage, direction from the residual angle
    always_comb begin
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] da;
        for (int k = 0; k < STEPS; k++) begin
            dx = cy_prev[k] >>> k;
            dy = cx_prev[k] >>> k;
            da = $signed({2'b00, csfv_pkg::ATAN_Q30[k]});
            if (!cz_prev[k][ZW-1]) begin
                cx_next[k] = cx_prev[k] - dx;
                cy_next[k] = cy_prev[k] + dy;
                cz_next[k] = cz_prev[k] - da;
            end else begin
                cx_next[k] = cx_prev[k] + dx;
                cy_next[k] = cy_prev[k] - dy;
                cz_next[k] = cz_prev[k] + da;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STEPS; k++) begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                cz_reg[k] <= cz_next[k];
            end
        end
    end

    // Carry the angle sign to the rotation output, the result sign to the end
    always_ff @(posedge aclk) begin
        if (en) begin
            nn_reg[0] <= neg_in;
            for (int k = 1; k < NN_D; k++) begin
                nn_reg[k] <= nn_reg[k-1];
            end
            ng_reg[0] <= neg_fin;
            for (int k = 1; k < TW; k++) begin
                ng_reg[k] <= ng_reg[k-1];
            end
        end
    end

    // Divide |y| by x for the tangent
    always_comb begin
        y_fin   = cy_reg[STEPS-1];
        y_mag   = y_fin[XW-1] ? TW'(-y_fin) : TW'(y_fin);
        div_num = {y_mag, 30'b0};
        div_den = cx_reg[STEPS-1][csfv_pkg::DEN_TAN_W-1:0];
        neg_fin = y_fin[XW-1] ^ nn_reg[NN_D-1];
    end

    csfv_udiv #(
        .NUM_W (TW + 30),
        .DEN_W (csfv_pkg::DEN_TAN_W),
        .QUO_W (TW)
    ) u_div (
        .aclk    (aclk),
        .en      (en),
        .num_in  (div_num),
        .den_in  (div_den),
        .quo_out (tan_mag)
    );

    assign tan_neg = ng_reg[TW-1];

endmodule

FILE: rtl/cube_sphere_face_vertex.sv
// Cube-sphere +X face vertex generator.
// Input word: grid row and column. Output word: unit vector and in_range.
// Both channels use valid/ready; a word moves when valid and ready are high.
// cfg_wr_en/cfg_wr_data write the subdivision level (reset value 6, values
// above MAX_SUBDIV act as MAX_SUBDIV); write it only while the block is idle.
// Throughput: one word per cycle unless the receiver stalls. The pipeline
// depth is set by two 30-stage rotation CORDICs with 32-stage dividers for
// the tangents, a 32-stage square root for the norm and FRAC_BITS+1 stage
// dividers for the components, one step per register stage.
// The output register is backed by a one-word skid register. When the
// receiver stalls, one more word drains into the skid register, then s_ready
// drops and the whole pipeline holds; nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and output registers
// and restores the subdivision level.
// Depends on csfv_pkg, csfv_tan and csfv_udiv.
module cube_sphere_face_vertex #(
    parameter int MAX_SUBDIV = csfv_pkg::MAX_SUBDIV_DEF,
    parameter int FRAC_BITS  = csfv_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration
    input  logic                               cfg_wr_en,
    input  logic [csfv_pkg::CFG_W-1:0]         cfg_wr_data,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [csfv_pkg::IDX_W-1:0]         s_row_index,
    input  logic [csfv_pkg::IDX_W-1:0]         s_col_index,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [csfv_pkg::OUT_W-1:0]  m_vec_x,
    output logic signed [csfv_pkg::OUT_W-1:0]  m_vec_y,
    output logic signed [csfv_pkg::OUT_W-1:0]  m_vec_z,
    output logic                               m_in_range
);

    localparam int MW      = MAX_SUBDIV + 1;
    localparam int LW      = $clog2(MAX_SUBDIV + 1);
    localparam int CW      = (MW > csfv_pkg::IDX_W) ? MW : csfv_pkg::IDX_W;
    localparam int SW      = CW + 2;
    localparam int TW      = csfv_pkg::TAN_W;
    localparam int DIV_LAT = FRAC_BITS + 1;
    localparam int DNUM_W  = FRAC_BITS + 32;
    localparam int QX      = (DIV_LAT > 17) ? DIV_LAT : 17;
    localparam int OW      = csfv_pkg::OUT_W;
    localparam int TQ_D    = 2 + csfv_pkg::SQRT_STEPS;
    localparam int SG_D    = TQ_D + DIV_LAT;
    localparam int PIPE_D  = 1 + csfv_pkg::TAN_LAT + TQ_D + DIV_LAT;
    localparam int RW      = csfv_pkg::ROOT_W;
    localparam int SRW     = RW + 2;

    logic                     adv;
    logic [csfv_pkg::CFG_W-1:0] subdiv_reg;

    // Stage 0
    logic [LW-1:0]  lvl_c;
    logic [MW-1:0]  n_c;
    logic [CW-1:0]  n_ext;
    logic [CW-1:0]  i_ext;
    logic [CW-1:0]  j_ext;
    logic signed [SW-1:0] num_r;
    logic signed [SW-1:0] num_c;
    logic           rng_c;
    logic [MW-1:0]  magr_reg;
    logic [MW-1:0]  magc_reg;
    logic           negr_reg;
    logic           negc_reg;
    logic [LW-1:0]  lvl_reg;

    // Valid and in_range travel with each word through every stage
    logic vld_reg [PIPE_D];
    logic rng_reg [PIPE_D];

    // Tangents
    logic [TW-1:0] t1_mag;
    logic [TW-1:0] t2_mag;
    logic          t1_neg;
    logic          t2_neg;

    // Norm path
    logic [TW-1:0]              tq1_reg [TQ_D];
    logic [TW-1:0]              tq2_reg [TQ_D];
    logic [1:0]                 sg_reg  [SG_D];
    logic [csfv_pkg::SQ_W-1:0]  sq1_reg;
    logic [csfv_pkg::SQ_W-1:0]  sq2_reg;
    logic [csfv_pkg::SQ_W-1:0]  sum_reg;

    logic [SRW-1:0]             rt_rem_reg  [csfv_pkg::SQRT_STEPS];
    logic [RW-1:0]              rt_root_reg [csfv_pkg::SQRT_STEPS];
    logic [csfv_pkg::SQ_W-1:0]  rt_bits_reg [csfv_pkg::SQRT_STEPS];
    logic [SRW-1:0]             rt_rem_prev  [csfv_pkg::SQRT_STEPS];
    logic [RW-1:0]              rt_root_prev [csfv_pkg::SQRT_STEPS];
    logic [csfv_pkg::SQ_W-1:0]  rt_bits_prev [csfv_pkg::SQRT_STEPS];
    logic [SRW-1:0]             rt_rem_next  [csfv_pkg::SQRT_STEPS];
    logic [RW-1:0]              rt_root_next [csfv_pkg::SQRT_STEPS];

    // Component division
    logic [RW-1:0]      norm;
    logic [DNUM_W-1:0]  half_norm;
    logic [DNUM_W-1:0]  dnum0;
    logic [DNUM_W-1:0]  dnum1;
    logic [DNUM_W-1:0]  dnum2;
    logic [DIV_LAT-1:0] q0;
    logic [DIV_LAT-1:0] q1;
    logic [DIV_LAT-1:0] q2;

    // Pipeline end and output registers
    logic                 pv;
    logic signed [OW-1:0] px;
    logic signed [OW-1:0] py;
    logic signed [OW-1:0] pz;
    logic                 prng;
    logic                 out_valid_reg;
    logic signed [OW-1:0] out_x_reg;
    logic signed [OW-1:0] out_y_reg;
    logic signed [OW-1:0] out_z_reg;
    logic                 out_rng_reg;
    logic                 skid_valid_reg;
    logic signed [OW-1:0] skid_x_reg;
    logic signed [OW-1:0] skid_y_reg;
    logic signed [OW-1:0] skid_z_reg;
    logic                 skid_rng_reg;

    // Sign the rounded quotient into a component, saturating at 16 bits
    function automatic logic signed [OW-1:0] sat_comp(input logic [DIV_LAT-1:0] q,
                                                      input logic neg);
        logic [QX-1:0] qx;
        logic signed [OW-1:0] r;
        qx = QX'(q);
        if (neg) begin
            if (qx > QX'(32768)) begin
                r = {1'b1, {(OW-1){1'b0}}};
            end else begin
                r = OW'(-qx);
            end
        end else begin
            if (qx > QX'(32767)) begin
                r = {1'b0, {(OW-1){1'b1}}};
            end else begin
                r = qx[OW-1:0];
            end
        end
        return r;
    endfunction

    // The pipeline moves whenever the skid register is free
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    // Subdivision level register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subdiv_reg <= csfv_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            subdiv_reg <= cfg_wr_data;
        end
    end

    // Clamp the level, check the grid bounds, form the signed step counts
    always_comb begin
        lvl_c = (subdiv_reg > csfv_pkg::CFG_W'(MAX_SUBDIV)) ?
                LW'(MAX_SUBDIV) : LW'(subdiv_reg);
        n_c   = MW'(1) << lvl_c;
        n_ext = CW'(n_c);
        i_ext = CW'(s_row_index);
        j_ext = CW'(s_col_index);
        rng_c = (i_ext <= n_ext) && (j_ext <= n_ext);
        num_r = $signed({2'b00, n_ext}) - $signed({1'b0, i_ext, 1'b0});
        num_c = $signed({1'b0, j_ext, 1'b0}) - $signed({2'b00, n_ext});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            magr_reg <= num_r[SW-1] ? MW'(-num_r) : MW'(num_r);
            magc_reg <= num_c[SW-1] ? MW'(-num_c) : MW'(num_c);
            negr_reg <= num_r[SW-1];
            negc_reg <= num_c[SW-1];
            lvl_reg  <= lvl_c;
        end
    end

    // Advance valid bits; in_range rides along as payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_D; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < PIPE_D; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rng_reg[0] <= rng_c;
            for (int k = 1; k < PIPE_D; k++) begin
                rng_reg[k] <= rng_reg[k-1];
            end
        end
    end

    // Latitude tangent from the row, longitude tangent from the column
    csfv_tan #(
        .MAG_W (MW),
        .LVL_W (LW)
    ) u_tan_row (
        .aclk    (aclk),
        .en      (adv),
        .mag_in  (magr_reg),
        .lvl_in  (lvl_reg),
        .neg_in  (negr_reg),
        .tan_mag (t2_mag),
        .tan_neg (t2_neg)
    );

    csfv_tan #(
        .MAG_W (MW),
        .LVL_W (LW)
    ) u_tan_col (
        .aclk    (aclk),
        .en      (adv),
        .mag_in  (magc_reg),
        .lvl_in  (lvl_reg),
        .neg_in  (negc_reg),
        .tan_mag (t1_mag),
        .tan_neg (t1_neg)
    );

    // Square, sum, and hold magnitudes and signs until the division
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_reg <= csfv_pkg::SQ_W'(t1_mag) * csfv_pkg::SQ_W'(t1_mag);
            sq2_reg <= csfv_pkg::SQ_W'(t2_mag) * csfv_pkg::SQ_W'(t2_mag);
            sum_reg <= (csfv_pkg::SQ_W'(1) << 60) + sq1_reg + sq2_reg;
            tq1_reg[0] <= t1_mag;
            tq2_reg[0] <= t2_mag;
            for (int k = 1; k < TQ_D; k++) begin
                tq1_reg[k] <= tq1_reg[k-1];
                tq2_reg[k] <= tq2_reg[k-1];
            end
            // y follows tan a2, z follows -tan a1
            sg_reg[0] <= {t2_neg, !t1_neg};
            for (int k = 1; k < SG_D; k++) begin
                sg_reg[k] <= sg_reg[k-1];
            end
        end
    end

    // Square root, one result bit per stage
    always_comb begin
        rt_rem_prev[0]  = '0;
        rt_root_prev[0] = '0;
        rt_bits_prev[0] = sum_reg;
        for (int k = 1; k < csfv_pkg::SQRT_STEPS; k++) begin
            rt_rem_prev[k]  = rt_rem_reg[k-1];
            rt_root_prev[k] = rt_root_reg[k-1];
            rt_bits_prev[k] = rt_bits_reg[k-1];
        end
    end

    always_comb begin
        logic [SRW+1:0] t;
        logic [SRW+1:0] trial;
        logic           ge;
        for (int k = 0; k < csfv_pkg::SQRT_STEPS; k++) begin
            t     = {rt_rem_prev[k], rt_bits_prev[k][csfv_pkg::SQ_W-1 -: 2]};
            trial = {2'b00, rt_root_prev[k], 2'b01};
            ge    = (t >= trial);
            rt_rem_next[k]  = ge ? SRW'(t - trial) : SRW'(t);
            rt_root_next[k] = {rt_root_prev[k][RW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < csfv_pkg::SQRT_STEPS; k++) begin
                rt_rem_reg[k]  <= rt_rem_next[k];
                rt_root_reg[k] <= rt_root_next[k];
                rt_bits_reg[k] <= rt_bits_prev[k] << 2;
            end
        end
    end

    // Divide each magnitude, scaled and biased by half the norm, by the norm
    always_comb begin
        norm      = rt_root_reg[csfv_pkg::SQRT_STEPS-1];
        half_norm = DNUM_W'(norm >> 1);
        dnum0     = (DNUM_W'(csfv_pkg::Q30_ONE) << FRAC_BITS) + half_norm;
        dnum1     = (DNUM_W'(tq2_reg[TQ_D-1]) << FRAC_BITS) + half_norm;
        dnum2     = (DNUM_W'(tq1_reg[TQ_D-1]) << FRAC_BITS) + half_norm;
    end

    csfv_udiv #(
        .NUM_W (DNUM_W),
        .DEN_W (csfv_pkg::NORM_W),
        .QUO_W (DIV_LAT)
    ) u_div_x (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (dnum0),
        .den_in  (norm[csfv_pkg::NORM_W-1:0]),
        .quo_out (q0)
    );

    csfv_udiv #(
        .NUM_W (DNUM_W),
        .DEN_W (csfv_pkg::NORM_W),
        .QUO_W (DIV_LAT)
    ) u_div_y (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (dnum1),
        .den_in  (norm[csfv_pkg::NORM_W-1:0]),
        .quo_out (q1)
    );

    csfv_udiv #(
        .NUM_W (DNUM_W),
        .DEN_W (csfv_pkg::NORM_W),
        .QUO_W (DIV_LAT)
    ) u_div_z (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (dnum2),
        .den_in  (norm[csfv_pkg::NORM_W-1:0]),
        .quo_out (q2)
    );

    // Sign, saturate, and zero the word when the indices miss the grid
    always_comb begin
        pv   = vld_reg[PIPE_D-1];
        prng = rng_reg[PIPE_D-1];
        px   = prng ? sat_comp(q0, 1'b0)            : '0;
        py   = prng ? sat_comp(q1, sg_reg[SG_D-1][1]) : '0;
        pz   = prng ? sat_comp(q2, sg_reg[SG_D-1][0]) : '0;
    end

    // Output register with skid: drain the skid first, else take the pipe end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= pv;
        end else if (pv) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_x_reg   <= skid_x_reg;
                out_y_reg   <= skid_y_reg;
                out_z_reg   <= skid_z_reg;
                out_rng_reg <= skid_rng_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_x_reg   <= px;
            out_y_reg   <= py;
            out_z_reg   <= pz;
            out_rng_reg <= prng;
        end else begin
            skid_x_reg   <= px;
            skid_y_reg   <= py;
            skid_z_reg   <= pz;
            skid_rng_reg <= prng;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_vec_x    = out_x_reg;
    assign m_vec_y    = out_y_reg;
    assign m_vec_z    = out_z_reg;
    assign m_in_range = out_rng_reg;

    // The skid register only holds a word behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without an output word");

    // The skid register fills only while the receiver stalls a held word
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without a stall");

    // Words off the grid carry zero components
    a_off_grid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_range) |-> (m_vec_x == '0 && m_vec_y == '0 && m_vec_z == '0))
        else $error("off-grid word with nonzero components");

    // On the +X face the x component is always positive
    a_x_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_range) |-> (m_vec_x > 0))
        else $error("x component not positive");

endmodule

FILE: tb/sv/tb.sv
// Testbench for cube_sphere_face_vertex: drives grid points, predicts each unit vector
// with its own CORDIC/isqrt model and checks every result word in order.
// Depends on csfv_pkg and the cube_sphere_face_vertex RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 100 + csfv_pkg::FRAC_BITS_DEF + 30;
    localparam int IDLE_PCT    = 28;

    typedef struct {
        logic signed [csfv_pkg::OUT_W-1:0] x;
        logic signed [csfv_pkg::OUT_W-1:0] y;
        logic signed [csfv_pkg::OUT_W-1:0] z;
        logic                              in_range;
    } vertex_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [csfv_pkg::CFG_W-1:0]        cfg_wr_data;
    logic                              s_valid;
    logic                              s_ready;
    logic [csfv_pkg::IDX_W-1:0]        s_row_index;
    logic [csfv_pkg::IDX_W-1:0]        s_col_index;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [csfv_pkg::OUT_W-1:0] m_vec_x;
    logic signed [csfv_pkg::OUT_W-1:0] m_vec_y;
    logic signed [csfv_pkg::OUT_W-1:0] m_vec_z;
    logic                              m_in_range;

    // Model copy of the subdivision register
    logic [csfv_pkg::CFG_W-1:0] level_model;

    vertex_t expected_vertices[$];
    int      error_count;
    int      words_sent;
    int      results_checked;
    int      input_stall_cycles;
    bit      sender_idle_en;
    bit      receiver_idle_en;
    int      hold_request;

    always #1 aclk = ~aclk;

    cube_sphere_face_vertex dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_vec_x     (m_vec_x),
        .m_vec_y     (m_vec_y),
        .m_vec_z     (m_vec_z),
        .m_in_range  (m_in_range)
    );

    // Tangent of pi/4 * num / 2^lvl in Q30, by 30 rotation steps
    function automatic longint tangent_q30(longint num, int lvl);
        longint     mag, z, x, y, dx, dy;
        logic [63:0] y_mag, den, quot;
        bit         neg;
        mag = (num < 0) ? -num : num;
        z = (mag * longint'(csfv_pkg::QUARTER_PI)) >>> lvl;
        x = longint'(1) << 30;
        y = 0;
        for (int k = 0; k < csfv_pkg::CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(csfv_pkg::ATAN_Q30[k]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(csfv_pkg::ATAN_Q30[k]);
            end
        end
        neg   = (y < 0) != (num < 0);
        y_mag = (y < 0) ? -y : y;
        den   = x;
        quot  = (y_mag << 30) / den;
        return neg ? -longint'(quot) : longint'(quot);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Round half away from zero, then saturate to the output width
    function automatic logic [csfv_pkg::OUT_W-1:0] scale_component(longint a,
                                                                   logic [63:0] norm);
        logic [63:0] mag, q, neg_q;
        mag   = (a < 0) ? -a : a;
        q     = ((mag << csfv_pkg::FRAC_BITS_DEF) + norm / 2) / norm;
        neg_q = -q;
        if (a < 0)
            return (q > 64'd32768) ? 16'h8000 : neg_q[csfv_pkg::OUT_W-1:0];
        return (q > 64'd32767) ? 16'h7FFF : q[csfv_pkg::OUT_W-1:0];
    endfunction

    function automatic vertex_t predict_vertex(logic [csfv_pkg::IDX_W-1:0] row,
                                               logic [csfv_pkg::IDX_W-1:0] col,
                                               logic [csfv_pkg::CFG_W-1:0] level);
        vertex_t     v;
        int          lvl;
        longint      n, i, j, lat_tan, lon_tan, a1, a2;
        logic [63:0] m0, m1, m2, norm;
        lvl = (level > csfv_pkg::MAX_SUBDIV_DEF) ? csfv_pkg::MAX_SUBDIV_DEF : int'(level);
        n = longint'(1) << lvl;
        i = longint'(row);
        j = longint'(col);
        v.x = '0;
        v.y = '0;
        v.z = '0;
        v.in_range = 1'b0;
        if (i > n || j > n) return v;
        lat_tan = tangent_q30(n - 2 * i, lvl);
        lon_tan = tangent_q30(2 * j - n, lvl);
        a1 = lat_tan;
        a2 = -lon_tan;
        m0 = 64'd1 << 30;
        m1 = (a1 < 0) ? -a1 : a1;
        m2 = (a2 < 0) ? -a2 : a2;
        norm = root_floor(m0 * m0 + m1 * m1 + m2 * m2);
        v.x = scale_component(longint'(m0), norm);
        v.y = scale_component(a1, norm);
        v.z = scale_component(a2, norm);
        v.in_range = 1'b1;
        return v;
    endfunction

    // Mostly grid points, some anywhere in the 9-bit index range
    function automatic logic [csfv_pkg::IDX_W-1:0] pick_index();
        int n;
        n = 1 << ((level_model > csfv_pkg::MAX_SUBDIV_DEF) ?
                  csfv_pkg::MAX_SUBDIV_DEF : int'(level_model));
        if ($urandom_range(0, 99) < 85)
            return csfv_pkg::IDX_W'($urandom_range(0, n));
        return csfv_pkg::IDX_W'($urandom_range(0, (1 << csfv_pkg::IDX_W) - 1));
    endfunction

    // Offer one word, idling first at random, and record its expected vertex
    task automatic send_word(logic [csfv_pkg::IDX_W-1:0] row,
                             logic [csfv_pkg::IDX_W-1:0] col);
        @(negedge aclk);
        while (sender_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_index <= row;
        s_col_index <= col;
        do @(posedge aclk); while (!s_ready);
        expected_vertices.insert(expected_vertices.size(),
                                 predict_vertex(row, col, level_model));
        words_sent++;
    endtask

    // Drop valid and hold until every expected result is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_vertices.size() > 0) @(posedge aclk);
    endtask

    task automatic write_level(logic [csfv_pkg::CFG_W-1:0] level);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        level_model = level;
    endtask

    task automatic send_random_words(int count);
        for (int k = 0; k < count; k++) send_word(pick_index(), pick_index());
    endtask

    // Grid corners, center, edges and points just outside at the reset level
    task automatic test_reset_level();
        send_word(9'd0, 9'd0);
        send_word(9'd0, 9'd64);
        send_word(9'd64, 9'd0);
        send_word(9'd64, 9'd64);
        send_word(9'd32, 9'd32);
        send_word(9'd0, 9'd32);
        send_word(9'd32, 9'd0);
        send_word(9'd1, 9'd63);
        send_word(9'd65, 9'd0);
        send_word(9'd0, 9'd65);
        send_word(9'd65, 9'd65);
        send_word(9'd511, 9'd511);
        drain_results();
    endtask

    // Smallest grid, then a level above the maximum that must clamp
    task automatic test_level_extremes();
        write_level(4'd0);
        send_word(9'd0, 9'd0);
        send_word(9'd1, 9'd1);
        send_word(9'd0, 9'd1);
        send_word(9'd1, 9'd0);
        send_word(9'd2, 9'd0);
        drain_results();
        write_level(4'd15);
        send_word(9'd256, 9'd256);
        send_word(9'd0, 9'd256);
        send_word(9'd256, 9'd0);
        send_word(9'd128, 9'd128);
        send_word(9'd257, 9'd0);
        send_word(9'd0, 9'd257);
        drain_results();
    endtask

    // Every register value, each with its own batch of random words
    task automatic test_random_levels();
        logic [csfv_pkg::CFG_W-1:0] level_order[16] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd9,
                                                        4'd5, 4'd1, 4'd12, 4'd7, 4'd2,
                                                        4'd4, 4'd6, 4'd10, 4'd14, 4'd11,
                                                        4'd13};
        for (int k = 0; k < 16; k++) begin
            write_level(level_order[k]);
            send_random_words(100);
            drain_results();
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        write_level(4'd8);
        sender_idle_en = 1'b0;
        hold_request   = 400;
        send_random_words(200);
        drain_results();
        sender_idle_en = 1'b1;
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_steady_stream();
        write_level(4'd5);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        send_random_words(125);
        drain_results();
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    // Result side: random stalls, plus any long hold-off the tests request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (receiver_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        vertex_t want;
        if (aresetn && s_valid && !s_ready) input_stall_cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_vertices.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                want = expected_vertices.pop_front();
                results_checked++;
                if (m_vec_x !== want.x) begin
                    $error("vec_x mismatch: expected %0d, got %0d", want.x, m_vec_x);
                    error_count++;
                end
                if (m_vec_y !== want.y) begin
                    $error("vec_y mismatch: expected %0d, got %0d", want.y, m_vec_y);
                    error_count++;
                end
                if (m_vec_z !== want.z) begin
                    $error("vec_z mismatch: expected %0d, got %0d", want.z, m_vec_z);
                    error_count++;
                end
                if (m_in_range !== want.in_range) begin
                    $error("in_range mismatch: expected %0b, got %0b",
                           want.in_range, m_in_range);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAIL cube_sphere_face_vertex");
        $finish;
    end

    initial begin : main
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        s_valid            = 1'b0;
        s_row_index        = '0;
        s_col_index        = '0;
        level_model        = csfv_pkg::CFG_RESET;
        error_count        = 0;
        words_sent         = 0;
        results_checked    = 0;
        input_stall_cycles = 0;
        sender_idle_en     = 1'b1;
        receiver_idle_en   = 1'b1;
        hold_request       = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_level();
        test_level_extremes();
        test_random_levels();
        test_backpressure();
        test_steady_stream();

        // Let any stray word surface before closing
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_vertices.size() != 0) begin
            $error("%0d expected results never arrived", expected_vertices.size());
            error_count++;
        end
        $display("Sent %0d grid points over all 16 level settings; checked %0d vectors.",
                 words_sent, results_checked);
        $display("Input stalled %0d cycles under receiver hold-off; %0d errors.",
                 input_stall_cycles, error_count);
        if (error_count == 0)
            $display("PASS cube_sphere_face_vertex");
        else
            $display("FAIL cube_sphere_face_vertex");
        $finish;
    end

endmodule
